/* src/grid_first_fit_rect_allocator_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the grid first-fit rectangle allocator
// Short forms for the clocked checks at the end of the core.
// ----------------------------------------------------------------------------
`ifndef GRID_FIRST_FIT_RECT_ALLOCATOR_CORE_DEFINES_SVH
`define GRID_FIRST_FIT_RECT_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define GFFRA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define GFFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/gffra_pkg.sv */
// ----------------------------------------------------------------------------
// gffra_pkg
// Shared constants, codes and state type of the grid rectangle allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gffra_pkg;

	localparam int DEF_MAX_COLUMNS = 16;
	localparam int DEF_MAX_ROWS    = 16;
	localparam int DEF_MAX_ITEMS   = 64;

	localparam int OP_W      = 2;
	localparam int ID_IN_W   = 6;
	localparam int SIZE_W    = 5;
	localparam int CELL_W    = 4;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_W-1:0] GRID_RESET = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_ADD        = 2'd0,
		OP_REMOVE     = 2'd1,
		OP_QUERY_CELL = 2'd2,
		OP_QUERY_ITEM = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_COLUMNS = 1'b0,
		REG_GRID_ROWS    = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_INIT,
		ST_ADD_RD,
		ST_ADD_CHK,
		ST_ADD_PICK,
		ST_ROW_RD,
		ST_ROW_WR,
		ST_REC_RD,
		ST_REC_CHK,
		ST_CELL_RD,
		ST_CELL_CHK,
		ST_FINISH
	} state_t;

endpackage

/* src/gffra_ram.sv */
// ----------------------------------------------------------------------------
// gffra_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gffra_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* src/gffra_row_unit.sv */
// ----------------------------------------------------------------------------
// gffra_row_unit
// Shared row-mask unit: narrows the candidate column set against one row of
// the bitmap, and forms the row word with a span marked or freed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gffra_row_unit #(
	parameter int MAX_COLUMNS = gffra_pkg::DEF_MAX_COLUMNS,
	parameter int CX_W        = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
	input  logic [MAX_COLUMNS-1:0]      row_data,
	input  logic [gffra_pkg::SIZE_W-1:0] span_w,
	input  logic [CX_W-1:0]             span_x,
	input  logic [MAX_COLUMNS-1:0]      fit_in,
	output logic [MAX_COLUMNS-1:0]      fit_out,
	output logic [MAX_COLUMNS-1:0]      row_marked,
	output logic [MAX_COLUMNS-1:0]      row_freed
);

	import gffra_pkg::*;

	logic [MAX_COLUMNS-1:0] clash;
	logic [MAX_COLUMNS-1:0] span;

	// a corner clashes when any occupied cell lies under its span in this row
	always_comb begin
		clash = '0;
		for (int x = 0; x < MAX_COLUMNS; x++) begin
			for (int j = 0; j < MAX_COLUMNS; j++) begin
				if (row_data[j] && (j >= x) && (j < x + int'(span_w))) begin
					clash[x] = 1'b1;
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_COLUMNS; j++) begin
			span[j] = (j >= int'(span_x)) && (j < int'(span_x) + int'(span_w));
		end
	end

	assign fit_out    = fit_in & ~clash;
	assign row_marked = row_data | span;
	assign row_freed  = row_data & ~span;

endmodule

/* src/grid_first_fit_rect_allocator_core.sv */
// ----------------------------------------------------------------------------
// grid_first_fit_rect_allocator_core: first-fit rectangle allocator on a grid
// One word at a time; the next word is taken the cycle after a result is loaded.
// Add checks candidate rows one bitmap row at a time (one bitmap RAM port, one
// read per row check); a zero-sized item writes no bitmap rows. After reset a
// clearing pass clears bitmap and item table; no word is taken meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_first_fit_rect_allocator_core_defines.svh"

module grid_first_fit_rect_allocator_core #(
	parameter int MAX_COLUMNS = gffra_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = gffra_pkg::DEF_MAX_ROWS,
	parameter int MAX_ITEMS   = gffra_pkg::DEF_MAX_ITEMS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [gffra_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gffra_pkg::CFG_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [gffra_pkg::OP_W-1:0]      opcode,
	input  logic [gffra_pkg::ID_IN_W-1:0]   item_id,
	input  logic [gffra_pkg::SIZE_W-1:0]    item_width,
	input  logic [gffra_pkg::SIZE_W-1:0]    item_height,
	input  logic [gffra_pkg::CELL_W-1:0]    cell_x,
	input  logic [gffra_pkg::CELL_W-1:0]    cell_y,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            ok,
	output logic                            occupied,
	output logic [gffra_pkg::CELL_W-1:0]    pos_x,
	output logic [gffra_pkg::CELL_W-1:0]    pos_y
);

	import gffra_pkg::*;

	localparam int CX_W    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RA_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ID_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int MAX_DIM = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
	localparam int CALC_W  = $clog2(MAX_DIM + (1 << SIZE_W)) + 1;
	localparam int CLR_N   = (MAX_ITEMS > MAX_ROWS) ? MAX_ITEMS : MAX_ROWS;
	localparam int CLR_W   = (CLR_N > 1) ? $clog2(CLR_N) : 1;

	// item record: {valid, x, y, w, h}
	localparam int REC_H_LO = 0;
	localparam int REC_W_LO = SIZE_W;
	localparam int REC_Y_LO = 2 * SIZE_W;
	localparam int REC_X_LO = REC_Y_LO + RA_W;
	localparam int REC_W    = REC_X_LO + CX_W + 1;

	state_t state_q, state_d;

	logic [CFG_W-1:0]  grid_columns_q, grid_rows_q;
	logic [CALC_W-1:0] cols_eff, rows_eff;

	op_t                op_q;
	logic [ID_IN_W-1:0] id_q;
	logic [SIZE_W-1:0]  w_q, h_q;
	logic [CX_W-1:0]    x_q;
	logic [CALC_W-1:0]  y_q, dy_q;
	logic [MAX_COLUMNS-1:0] fit_q;
	logic               mark_q;
	logic               res_ok_q, res_occ_q;
	logic [CELL_W-1:0]  res_x_q, res_y_q;
	logic [CLR_W-1:0]   clr_q;

	logic               out_valid_q, ok_q, occupied_q;
	logic [CELL_W-1:0]  pos_x_q, pos_y_q;

	logic [CALC_W-1:0]      row_idx;
	logic                   last_row;
	logic                   add_fail;
	logic                   item_id_ok, cell_ok;
	logic                   out_load;
	logic [MAX_COLUMNS-1:0] fit_init, fit_next;
	logic [CX_W-1:0]        first_x;

	logic                   occ_we;
	logic [RA_W-1:0]        occ_wa;
	logic [MAX_COLUMNS-1:0] occ_wd, occ_rd;
	logic [MAX_COLUMNS-1:0] row_marked, row_freed;

	logic               rec_we;
	logic [ID_W-1:0]    rec_wa;
	logic [REC_W-1:0]   rec_wd, rec_rd;
	logic               rec_v;
	logic [CX_W-1:0]    rec_x;
	logic [RA_W-1:0]    rec_y;
	logic [SIZE_W-1:0]  rec_w, rec_h;

	assign cols_eff = (CALC_W'(grid_columns_q) > CALC_W'(MAX_COLUMNS)) ?
		CALC_W'(MAX_COLUMNS) : CALC_W'(grid_columns_q);
	assign rows_eff = (CALC_W'(grid_rows_q) > CALC_W'(MAX_ROWS)) ?
		CALC_W'(MAX_ROWS) : CALC_W'(grid_rows_q);

	assign item_id_ok = int'(item_id) < MAX_ITEMS;
	assign cell_ok    = (int'(cell_x) < MAX_COLUMNS) && (int'(cell_y) < MAX_ROWS);

	assign row_idx  = y_q + dy_q;
	assign last_row = (dy_q + CALC_W'(1)) == CALC_W'(h_q);

	assign rec_v = rec_rd[REC_W-1];
	assign rec_x = rec_rd[REC_X_LO +: CX_W];
	assign rec_y = rec_rd[REC_Y_LO +: RA_W];
	assign rec_w = rec_rd[REC_W_LO +: SIZE_W];
	assign rec_h = rec_rd[REC_H_LO +: SIZE_W];

	// corners whose span stays inside the columns in use
	always_comb begin
		for (int x = 0; x < MAX_COLUMNS; x++) begin
			fit_init[x] = (x < int'(cols_eff)) && (x + int'(w_q) <= int'(cols_eff));
		end
	end

	// lowest surviving corner
	always_comb begin
		first_x = '0;
		for (int x = MAX_COLUMNS - 1; x >= 0; x--) begin
			if (fit_q[x]) begin
				first_x = CX_W'(x);
			end
		end
	end

	assign add_fail = (y_q >= rows_eff) || ((y_q + CALC_W'(h_q)) > rows_eff) ||
		(fit_init == '0);

	gffra_row_unit #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.CX_W        (CX_W)
	) u_row_unit (
		.row_data   (occ_rd),
		.span_w     (w_q),
		.span_x     (x_q),
		.fit_in     (fit_q),
		.fit_out    (fit_next),
		.row_marked (row_marked),
		.row_freed  (row_freed)
	);

	gffra_ram #(
		.WIDTH (MAX_COLUMNS),
		.DEPTH (MAX_ROWS),
		.AW    (RA_W)
	) u_occ_ram (
		.clk     (clk),
		.wr_en   (occ_we),
		.wr_addr (occ_wa),
		.wr_data (occ_wd),
		.rd_addr (RA_W'(row_idx)),
		.rd_data (occ_rd)
	);

	gffra_ram #(
		.WIDTH (REC_W),
		.DEPTH (MAX_ITEMS),
		.AW    (ID_W)
	) u_rec_ram (
		.clk     (clk),
		.wr_en   (rec_we),
		.wr_addr (rec_wa),
		.wr_data (rec_wd),
		.rd_addr (ID_W'(id_q)),
		.rd_data (rec_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_W'(CLR_N - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (op_t'(opcode))
						OP_ADD:        state_d = item_id_ok ? ST_ADD_INIT : ST_FINISH;
						OP_REMOVE:     state_d = item_id_ok ? ST_REC_RD : ST_FINISH;
						OP_QUERY_ITEM: state_d = item_id_ok ? ST_REC_RD : ST_FINISH;
						OP_QUERY_CELL: state_d = cell_ok ? ST_CELL_RD : ST_FINISH;
						default:       state_d = ST_FINISH;
					endcase
				end
			end
			ST_ADD_INIT: begin
				if (add_fail) begin
					state_d = ST_FINISH;
				end else if (h_q == '0) begin
					state_d = ST_ADD_PICK;
				end else begin
					state_d = ST_ADD_RD;
				end
			end
			ST_ADD_RD: state_d = ST_ADD_CHK;
			ST_ADD_CHK: begin
				if (fit_next == '0) begin
					state_d = ST_ADD_INIT;
				end else if (last_row) begin
					state_d = ST_ADD_PICK;
				end else begin
					state_d = ST_ADD_RD;
				end
			end
			ST_ADD_PICK: begin
				state_d = ((w_q == '0) || (h_q == '0)) ? ST_FINISH : ST_ROW_RD;
			end
			ST_ROW_RD: state_d = ST_ROW_WR;
			ST_ROW_WR: state_d = last_row ? ST_FINISH : ST_ROW_RD;
			ST_REC_RD: state_d = ST_REC_CHK;
			ST_REC_CHK: begin
				if ((op_q == OP_REMOVE) && rec_v && (rec_w != '0) && (rec_h != '0)) begin
					state_d = ST_ROW_RD;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_CELL_RD:  state_d = ST_CELL_CHK;
			ST_CELL_CHK: state_d = ST_FINISH;
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
		occ_we   = 1'b0;
		occ_wa   = RA_W'(row_idx);
		occ_wd   = mark_q ? row_marked : row_freed;
		rec_we   = 1'b0;
		rec_wa   = ID_W'(id_q);
		rec_wd   = '0;
		case (state_q)
			ST_CLEAR: begin
				occ_we = int'(clr_q) < MAX_ROWS;
				occ_wa = RA_W'(clr_q);
				occ_wd = '0;
				rec_we = int'(clr_q) < MAX_ITEMS;
				rec_wa = ID_W'(clr_q);
			end
			ST_ADD_PICK: begin
				rec_we = 1'b1;
				rec_wd = {1'b1, first_x, RA_W'(y_q), w_q, h_q};
			end
			ST_ROW_WR: begin
				occ_we = 1'b1;
			end
			ST_REC_CHK: begin
				// drop the record of a removed item
				rec_we = (op_q == OP_REMOVE) && rec_v;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			out_valid_q    <= 1'b0;
			grid_columns_q <= GRID_RESET;
			grid_rows_q    <= GRID_RESET;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_GRID_COLUMNS: grid_columns_q <= cfg_data;
					REG_GRID_ROWS:    grid_rows_q    <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_q      <= op_t'(opcode);
					id_q      <= item_id;
					w_q       <= item_width;
					h_q       <= item_height;
					mark_q    <= (op_t'(opcode) == OP_ADD);
					x_q       <= CX_W'(cell_x);
					y_q       <= (op_t'(opcode) == OP_QUERY_CELL) ? CALC_W'(cell_y) : '0;
					dy_q      <= '0;
					res_ok_q  <= 1'b0;
					res_occ_q <= 1'b0;
					res_x_q   <= '0;
					res_y_q   <= '0;
				end
			end
			ST_ADD_INIT: begin
				fit_q <= fit_init;
				dy_q  <= '0;
			end
			ST_ADD_CHK: begin
				fit_q <= fit_next;
				// no corner left in this row: advance to the next candidate row
				if (fit_next == '0) begin
					y_q <= y_q + CALC_W'(1);
				end else begin
					dy_q <= dy_q + CALC_W'(1);
				end
			end
			ST_ADD_PICK: begin
				x_q      <= first_x;
				dy_q     <= '0;
				res_ok_q <= 1'b1;
				res_x_q  <= CELL_W'(first_x);
				res_y_q  <= CELL_W'(y_q);
			end
			ST_ROW_WR: begin
				dy_q <= dy_q + CALC_W'(1);
			end
			ST_REC_CHK: begin
				x_q  <= rec_x;
				y_q  <= CALC_W'(rec_y);
				w_q  <= rec_w;
				h_q  <= rec_h;
				dy_q <= '0;
				if (rec_v) begin
					res_ok_q <= 1'b1;
					if (op_q == OP_QUERY_ITEM) begin
						res_x_q <= CELL_W'(rec_x);
						res_y_q <= CELL_W'(rec_y);
					end
				end
			end
			ST_CELL_CHK: begin
				res_occ_q <= occ_rd[x_q];
			end
			default: begin
			end
		endcase
		if (out_load) begin
			ok_q       <= res_ok_q;
			occupied_q <= res_occ_q;
			pos_x_q    <= res_x_q;
			pos_y_q    <= res_y_q;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign occupied  = occupied_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;

	`GFFRA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "word accepted but block still ready")
	`GFFRA_ASSERT_IMPLY(a_pick_has_corner, clk, arst_n, state_q == ST_ADD_PICK, fit_q != '0, "placing with no surviving corner")
	`GFFRA_ASSERT_IMPLY(a_row_write_in_grid, clk, arst_n, state_q == ST_ROW_WR, row_idx < CALC_W'(MAX_ROWS), "bitmap write beyond the grid")
	`GFFRA_ASSERT_IMPLY(a_ok_not_occupied, clk, arst_n, out_valid, !(ok && occupied), "result reports ok and occupied together")

endmodule
